### rtl/core/z80_instruction_length_decoder_core_assert.svh
// Assertion macros used by the checker module of the length decoder.
`ifndef Z80_INSTRUCTION_LENGTH_DECODER_CORE_ASSERT_SVH
`define Z80_INSTRUCTION_LENGTH_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, inactive during reset.
`define Z80ILD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("z80ild assertion failed");

// Next-cycle implication, inactive during reset.
`define Z80ILD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("z80ild assertion failed");

// Next-cycle implication that also holds across reset.
`define Z80ILD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("z80ild assertion failed");

`endif

### rtl/core/z80ild_pkg.sv
// Package with opcode codes, variant codes and length tables of the length decoder.
package z80ild_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned VAR_W  = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [VAR_W-1:0]  cpu_var_t;
  typedef logic [1:0]        tlen_t;

  // CPU variant codes; the reserved code decodes as Z80
  localparam cpu_var_t CPU_Z80  = 2'd0;
  localparam cpu_var_t CPU_8080 = 2'd1;
  localparam cpu_var_t CPU_Z180 = 2'd2;

  // Prefix and special opcodes
  localparam byte_t OP_PFX_CB  = 8'hCB;
  localparam byte_t OP_PFX_ED  = 8'hED;
  localparam byte_t OP_PFX_DD  = 8'hDD;
  localparam byte_t OP_PFX_FD  = 8'hFD;
  localparam byte_t ED_LD16_MASK = 8'hC7;
  localparam byte_t ED_LD16_CODE = 8'h43;
  localparam byte_t IX_DISP_LO = 8'h34;
  localparam byte_t IX_DISP_HI = 8'h36;
  localparam byte_t LD_MEM_DST_MASK = 8'hF8;
  localparam byte_t LD_MEM_DST_CODE = 8'h70;
  localparam byte_t ED_OUT0_SKIP = 8'h31;
  localparam byte_t ED_TST_BIT  = 8'h10;
  localparam byte_t ED_TST_CODE = 8'h74;

  // Lengths of opcodes 00-3F
  localparam tlen_t LOW_LEN [64] = '{
    2'd1,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1, 2'd1,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd2,2'd3,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1, 2'd2,2'd1,2'd1,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd2,2'd3,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1, 2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1,
    2'd2,2'd3,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1, 2'd2,2'd1,2'd3,2'd1,2'd1,2'd1,2'd2,2'd1
  };

  // Lengths of opcodes C0-FF; zero marks a prefix slot
  localparam tlen_t HIGH_LEN [64] = '{
    2'd1,2'd1,2'd3,2'd3,2'd3,2'd1,2'd2,2'd1, 2'd1,2'd1,2'd3,2'd0,2'd3,2'd3,2'd2,2'd1,
    2'd1,2'd1,2'd3,2'd2,2'd3,2'd1,2'd2,2'd1, 2'd1,2'd1,2'd3,2'd2,2'd3,2'd0,2'd2,2'd1,
    2'd1,2'd1,2'd3,2'd1,2'd3,2'd1,2'd2,2'd1, 2'd1,2'd1,2'd3,2'd1,2'd3,2'd0,2'd2,2'd1,
    2'd1,2'd1,2'd3,2'd1,2'd3,2'd1,2'd2,2'd1, 2'd1,2'd1,2'd3,2'd1,2'd3,2'd0,2'd2,2'd1
  };

endpackage

### rtl/core/z80ild_if.sv
// Request and result channel interfaces of the length decoder.
interface z80ild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;

  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);
endinterface

interface z80ild_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] length_bytes;

  modport source (output valid, output length_bytes, input ready);
  modport sink   (input valid, input length_bytes, output ready);
endinterface

### rtl/core/z80ild_decode.sv
// Combinational length decode for the Z80, 8080 and Z180 rule sets.
module z80ild_decode (
  input  z80ild_pkg::cpu_var_t cpu_variant,
  input  z80ild_pkg::byte_t    first_byte,
  input  z80ild_pkg::byte_t    second_byte,
  output z80ild_pkg::len_t     length_bytes
);
  import z80ild_pkg::*;

  len_t  len_z80;
  len_t  len_8080;
  len_t  len_z180;
  len_t  low_b1;
  len_t  high_b1;
  len_t  low_b2;
  len_t  high_b2;
  logic  mem_src;
  logic  mem_dst;
  logic  disp_op;
  logic  ed_z180_hit;
  len_t  ed_z180_len;

  // Table lookups for both bytes
  assign low_b1  = {1'b0, LOW_LEN[first_byte[5:0]]};
  assign high_b1 = {1'b0, HIGH_LEN[first_byte[5:0]]};
  assign low_b2  = {1'b0, LOW_LEN[second_byte[5:0]]};
  assign high_b2 = {1'b0, HIGH_LEN[second_byte[5:0]]};

  assign mem_src = (second_byte[2:0] == 3'd6);
  assign mem_dst = ((second_byte & LD_MEM_DST_MASK) == LD_MEM_DST_CODE);
  assign disp_op = (second_byte >= IX_DISP_LO) && (second_byte <= IX_DISP_HI);

  // Z80 rules
  always_comb begin
    len_z80 = 3'd1;
    case (first_byte[7:6])
      2'd0: len_z80 = low_b1;
      2'd3: begin
        if (first_byte == OP_PFX_CB) begin
          len_z80 = 3'd2;
        end else if (first_byte == OP_PFX_ED) begin
          len_z80 = ((second_byte & ED_LD16_MASK) == ED_LD16_CODE) ? 3'd4 : 3'd2;
        end else if (first_byte == OP_PFX_DD || first_byte == OP_PFX_FD) begin
          case (second_byte[7:6])
            2'd0: len_z80 = low_b2 + 3'd1 + {2'b00, disp_op};
            2'd3: len_z80 = (second_byte == OP_PFX_CB) ? 3'd4 : high_b2 + 3'd1;
            default: len_z80 = (mem_src != mem_dst) ? 3'd3 : 3'd2;
          endcase
        end else begin
          len_z80 = high_b1;
        end
      end
      default: len_z80 = 3'd1;
    endcase
  end

  // 8080 rules: JR slots are NOP, prefix slots are JP or CALL
  always_comb begin
    len_8080 = 3'd1;
    case (first_byte[7:6])
      2'd0: len_8080 = (first_byte[2:0] == 3'd0) ? 3'd1 : low_b1;
      2'd3: len_8080 = (high_b1 == 3'd0) ? 3'd3 : high_b1;
      default: len_8080 = 3'd1;
    endcase
  end

  // Z180 additions: IN0/OUT0 and TST/TSTIO
  always_comb begin
    ed_z180_hit = 1'b0;
    ed_z180_len = 3'd2;
    if (first_byte == OP_PFX_ED) begin
      if (second_byte[7:6] == 2'd0) begin
        ed_z180_hit = 1'b1;
        ed_z180_len = (second_byte[2:1] == 2'b00 && second_byte != ED_OUT0_SKIP)
                      ? 3'd3 : 3'd2;
      end else if (second_byte[7:6] == 2'd1 &&
                   (second_byte | ED_TST_BIT) == ED_TST_CODE) begin
        ed_z180_hit = 1'b1;
        ed_z180_len = 3'd3;
      end
    end
    len_z180 = ed_z180_hit ? ed_z180_len : len_z80;
  end

  // Select by variant
  always_comb begin
    case (cpu_variant)
      CPU_8080: length_bytes = len_8080;
      CPU_Z180: length_bytes = len_z180;
      default:  length_bytes = len_z80;
    endcase
  end

endmodule

### rtl/core/z80_instruction_length_decoder_core.sv
// Top level of the instruction length decoder: input register, decode, result register.
//
//  channel | direction | payload                      | handshake
//  in_req  | in        | first_byte[8], second_byte[8] | valid/ready
//  out_rsp | out       | length_bytes[3]               | valid/ready
//  cfg     | in        | cpu_variant[2]                | cfg_wr_en
//
// One request per cycle sustained while results are taken; an accepted request passes
// through the input register, then is decoded into the result register.
// Reset (rst_n low, synchronous) empties both registers and selects Z80 rules.
// A stalled result holds; the input register still takes one more request.
module z80_instruction_length_decoder_core (
  input  logic                   clk,
  input  logic                   rst_n,
  z80ild_in_if.sink              in_req,
  z80ild_out_if.source           out_rsp,
  input  logic                   cfg_wr_en,
  input  z80ild_pkg::cpu_var_t   cfg_wr_data
);
  import z80ild_pkg::*;

  cpu_var_t cpu_variant_r;
  logic     in_vld_r;
  byte_t    first_r;
  byte_t    second_r;
  logic     out_vld_r;
  len_t     len_r;
  len_t     len_nxt;
  logic     out_load;
  logic     in_load;

  // Advance when the next stage is empty or draining
  assign out_load     = !out_vld_r || out_rsp.ready;
  assign in_load      = !in_vld_r || out_load;
  assign in_req.ready = in_load;

  // Hold the rule-set select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_variant_r <= CPU_Z80;
    end else if (cfg_wr_en) begin
      cpu_variant_r <= cfg_wr_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_req.valid) begin
      first_r  <= in_req.first_byte;
      second_r <= in_req.second_byte;
    end
  end

  z80ild_decode u_decode (
    .cpu_variant  (cpu_variant_r),
    .first_byte   (first_r),
    .second_byte  (second_r),
    .length_bytes (len_nxt)
  );

  // Register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_vld_r) begin
      len_r <= len_nxt;
    end
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.length_bytes = len_r;

endmodule

### rtl/core/z80ild_checker.sv
// Port-level checker of the length decoder and its bind to the top level.
`include "z80_instruction_length_decoder_core_assert.svh"

module z80ild_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_length
);

  // Reset empties the result side
  `Z80ILD_ASSERT_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

  // Every length lies between one and four bytes
  `Z80ILD_ASSERT_NOW(a_len_range, clk, rst_n, out_valid, out_length != 3'd0 && out_length <= 3'd4)

  // Requests are refused only behind a stalled result
  `Z80ILD_ASSERT_NOW(a_bp_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

  // A stalled result holds its length
  `Z80ILD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_length))

endmodule

bind z80_instruction_length_decoder_core z80ild_checker u_z80ild_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_length (out_rsp.length_bytes)
);
